[rtl/core/gbs_pkg.sv]
package gbs_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned MaxCols   = 64;
  localparam int unsigned MaxRows   = 64;
  localparam int unsigned ColBits   = $clog2(MaxCols);
  localparam int unsigned RowBits   = $clog2(MaxRows);
  localparam int unsigned AddrBits  = ColBits + RowBits;
  localparam int unsigned Depth     = MaxCols * MaxRows;
  localparam int unsigned SizeBits  = 7;
  localparam int unsigned WgtBits   = FracBits + 1;
  localparam int unsigned AccBits   = 32 + WgtBits + 2;
  localparam int unsigned PosBits   = ColBits + FracBits;
  localparam logic [WgtBits-1:0] OneFx  = WgtBits'(1) << FracBits;
  localparam logic [AccBits:0]   HalfFx = (AccBits+1)'(1) << (FracBits - 1);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_COLS   = 3'd0,
    REG_ROWS   = 3'd1,
    REG_INV    = 3'd2,
    REG_CENT_X = 3'd3,
    REG_CENT_Y = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SCX, S_LX, S_LY, S_R0, S_R1, S_R2, S_R3,
    S_B1, S_B2, S_B3, S_B4, S_B5, S_DONE
  } state_e;

  typedef struct packed {
    logic                we;
    logic [AddrBits-1:0] waddr;
    logic [31:0]         wdata;
    logic [AddrBits-1:0] raddr;
  } mem_req_t;

  // grid size in effect, clamped to [2, max]
  function automatic logic [SizeBits-1:0] eff_size(logic [SizeBits-1:0] r, logic [SizeBits-1:0] mx);
    logic [SizeBits-1:0] v;
    v = r;
    if (r < SizeBits'(2)) v = SizeBits'(2);
    else if (r > mx) v = mx;
    return v;
  endfunction

  // scaled position to lower cell and fraction: {cell, frac}
  function automatic logic [ColBits+WgtBits-1:0] locate(logic [63:0] p, logic [16:0] cen,
                                                       logic [SizeBits-1:0] sz);
    logic [16:0]         c;
    logic [47:0]         u;
    logic [47:0]         a;
    logic [SizeBits-1:0] szm1;
    logic [PosBits-1:0]  hi;
    logic [PosBits-1:0]  a2;
    logic [SizeBits-1:0] cl;
    logic [PosBits-1:0]  fr;
    c    = (cen > OneFx) ? OneFx : cen;
    u    = p[63:FracBits];
    a    = '0;
    szm1 = sz - SizeBits'(1);
    if (!p[63] && (p != 64'd0) && (u > {31'b0, c})) a = u - {31'b0, c};
    hi = {szm1[ColBits-1:0], {FracBits{1'b0}}};
    a2 = (a > {{(48-PosBits){1'b0}}, hi}) ? hi : a[PosBits-1:0];
    cl = {1'b0, a2[PosBits-1:FracBits]};
    if (cl > sz - SizeBits'(2)) cl = sz - SizeBits'(2);
    fr = a2 - {cl[ColBits-1:0], {FracBits{1'b0}}};
    return {cl[ColBits-1:0], fr[WgtBits-1:0]};
  endfunction

  // round half up then floor shift by the fraction bits
  function automatic logic [31:0] rnd_shift(logic signed [AccBits-1:0] v);
    logic [AccBits:0] t;
    t = {v[AccBits-1], v} + HalfFx;
    return t[FracBits+31:FracBits];
  endfunction

endpackage

[rtl/core/gbs_mem.sv]
module gbs_mem (
  input  logic                             clk_i,
  input  gbs_pkg::mem_req_t                req_i,
  output logic [31:0]                      rdata_o
);

  logic [31:0] mem [gbs_pkg::Depth];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

[rtl/core/grid_bilinear_sampler_core.sv]
// Bilinear grid sampler over a 64x64 grid of Q16.16 cells held in one
// single-port-read memory. Cell writes, cells with a bad index and the unused
// op load the output register as accepted; a cell read passes the read and
// done states; a sample is paced by one shared 32x33 scaling multiplier used
// for x then y, the four neighbour reads through the single memory read port
// and the six weight multiply-accumulate steps of one 32x18 multiplier. One
// item is in flight at a time; a new item is accepted only when the output
// register is empty or its transfer completes in that cycle. The user must
// write registers over the APB port only while the block is idle, which the
// block does not enforce. Cells read before being written give undefined data.
module grid_bilinear_sampler_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_x[5:0], cell_y[11:6], write_value[43:12], pos_x[75:44], pos_y[107:76], zero pad
  input  logic [111:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0]
  output logic [31:0]  m_axis_tdata,
  // status[0]
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned CB = gbs_pkg::ColBits;
  localparam int unsigned WB = gbs_pkg::WgtBits;
  localparam int unsigned SB = gbs_pkg::SizeBits;
  localparam int unsigned AB = gbs_pkg::AccBits;

  // configuration registers
  logic [SB-1:0] cols_q, rows_q;
  logic [31:0]   inv_q;
  logic [16:0]   cenx_q, ceny_q;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= SB'(gbs_pkg::MaxCols);
      rows_q <= SB'(gbs_pkg::MaxRows);
      inv_q  <= 32'd65536;
      cenx_q <= 17'd32768;
      ceny_q <= 17'd32768;
    end else if (cfg_wr) begin
      case (gbs_pkg::reg_e'(cfg_idx))
        gbs_pkg::REG_COLS:   cols_q <= pwdata[SB-1:0];
        gbs_pkg::REG_ROWS:   rows_q <= pwdata[SB-1:0];
        gbs_pkg::REG_INV:    inv_q  <= pwdata;
        gbs_pkg::REG_CENT_X: cenx_q <= pwdata[16:0];
        gbs_pkg::REG_CENT_Y: ceny_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (gbs_pkg::reg_e'(cfg_idx))
      gbs_pkg::REG_COLS:   prdata = {25'b0, cols_q};
      gbs_pkg::REG_ROWS:   prdata = {25'b0, rows_q};
      gbs_pkg::REG_INV:    prdata = inv_q;
      gbs_pkg::REG_CENT_X: prdata = {15'b0, cenx_q};
      gbs_pkg::REG_CENT_Y: prdata = {15'b0, ceny_q};
      default:             prdata = 32'd0;
    endcase
  end

  // input fields
  logic [CB-1:0] in_cx, in_cy;
  logic [31:0]   in_wv, in_px, in_py;
  logic [SB-1:0] cols, rows;
  logic          in_fire, in_bad;
  logic          out_free;

  assign in_cx   = s_axis_tdata[5:0];
  assign in_cy   = s_axis_tdata[11:6];
  assign in_wv   = s_axis_tdata[43:12];
  assign in_px   = s_axis_tdata[75:44];
  assign in_py   = s_axis_tdata[107:76];
  assign cols    = gbs_pkg::eff_size(cols_q, SB'(gbs_pkg::MaxCols));
  assign rows    = gbs_pkg::eff_size(rows_q, SB'(gbs_pkg::MaxRows));
  assign in_bad  = ({1'b0, in_cx} >= cols) || ({1'b0, in_cy} >= rows);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // sequencer state
  gbs_pkg::state_e       st_q, st_d;
  logic [31:0]           py_q, py_d;
  logic signed [63:0]    prod_q, prod_d;
  logic [CB-1:0]         x0_q, x0_d, y0_q, y0_d;
  logic [WB-1:0]         t_q, t_d, s_q, s_d;
  logic signed [AB-1:0]  acc_q, acc_d;
  logic [31:0]           r0_q, r0_d, r1_q, r1_d, res_q, res_d;
  logic                  ovld_q, ovld_d, osts_q, osts_d;
  logic [31:0]           odat_q, odat_d;
  gbs_pkg::mem_req_t     mreq;
  logic [31:0]           rdata;

  // shared multipliers
  logic [31:0]             mul_a;
  logic signed [64:0]      scale_full;
  logic [31:0]             mac_a;
  logic [WB-1:0]           mac_w;
  logic                    mac_add;
  logic signed [AB-1:0]    mac_p;
  logic [CB+WB-1:0]        loc;

  assign scale_full = $signed(mul_a) * $signed({1'b0, inv_q});
  assign mac_p = AB'($signed(mac_a) * $signed({1'b0, mac_w}));
  assign loc = gbs_pkg::locate(prod_q, (st_q == gbs_pkg::S_LX) ? cenx_q : ceny_q,
                               (st_q == gbs_pkg::S_LX) ? cols : rows);

  gbs_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= gbs_pkg::S_IDLE;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    py_q   <= py_d;
    prod_q <= prod_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    t_q    <= t_d;
    s_q    <= s_d;
    acc_q  <= acc_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    res_q  <= res_d;
    odat_q <= odat_d;
    osts_q <= osts_d;
  end

  // next state, datapath steering and output register
  always_comb begin
    st_d    = st_q;
    py_d    = py_q;
    prod_d  = prod_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    t_d     = t_q;
    s_d     = s_q;
    acc_d   = acc_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    res_d   = res_q;
    odat_d  = odat_q;
    osts_d  = osts_q;
    ovld_d  = ovld_q && !m_axis_tready;
    mul_a   = in_px;
    mac_a   = rdata;
    mac_w   = gbs_pkg::OneFx - t_q;
    mac_add = 1'b0;
    mreq.we    = 1'b0;
    mreq.waddr = {in_cy, in_cx};
    mreq.wdata = in_wv;
    mreq.raddr = {in_cy, in_cx};
    s_axis_tready = (st_q == gbs_pkg::S_IDLE) && out_free;
    case (st_q)
      gbs_pkg::S_IDLE: begin
        if (in_fire) begin
          case (gbs_pkg::op_e'(s_axis_tuser))
            gbs_pkg::OP_WRITE: begin
              mreq.we = !in_bad;
              ovld_d  = 1'b1;
              odat_d  = 32'd0;
              osts_d  = in_bad;
            end
            gbs_pkg::OP_READ: begin
              if (in_bad) begin
                ovld_d = 1'b1;
                odat_d = 32'd0;
                osts_d = 1'b1;
              end else begin
                st_d = gbs_pkg::S_RD;
              end
            end
            gbs_pkg::OP_SAMPLE: begin
              prod_d = scale_full[63:0];
              py_d   = in_py;
              st_d   = gbs_pkg::S_LX;
            end
            default: begin
              ovld_d = 1'b1;
              odat_d = 32'd0;
              osts_d = 1'b0;
            end
          endcase
        end
      end
      gbs_pkg::S_RD: begin
        res_d = rdata;
        st_d  = gbs_pkg::S_DONE;
      end
      gbs_pkg::S_SCX: begin
        st_d = gbs_pkg::S_LX;
      end
      gbs_pkg::S_LX: begin
        x0_d   = loc[CB+WB-1:WB];
        t_d    = loc[WB-1:0];
        mul_a  = py_q;
        prod_d = scale_full[63:0];
        st_d   = gbs_pkg::S_LY;
      end
      gbs_pkg::S_LY: begin
        y0_d = loc[CB+WB-1:WB];
        s_d  = loc[WB-1:0];
        st_d = gbs_pkg::S_R0;
      end
      // neighbour reads, one a cycle, blended as the data returns
      gbs_pkg::S_R0: begin
        mreq.raddr = {y0_q, x0_q};
        st_d = gbs_pkg::S_R1;
      end
      gbs_pkg::S_R1: begin
        mreq.raddr = {y0_q, x0_q + CB'(1)};
        acc_d = mac_p;
        st_d  = gbs_pkg::S_R2;
      end
      gbs_pkg::S_R2: begin
        mreq.raddr = {y0_q + CB'(1), x0_q};
        mac_w = t_q;
        acc_d = acc_q + mac_p;
        st_d  = gbs_pkg::S_R3;
      end
      gbs_pkg::S_R3: begin
        mreq.raddr = {y0_q + CB'(1), x0_q + CB'(1)};
        r0_d  = gbs_pkg::rnd_shift(acc_q);
        acc_d = mac_p;
        st_d  = gbs_pkg::S_B1;
      end
      gbs_pkg::S_B1: begin
        mac_w = t_q;
        acc_d = acc_q + mac_p;
        st_d  = gbs_pkg::S_B2;
      end
      gbs_pkg::S_B2: begin
        r1_d = gbs_pkg::rnd_shift(acc_q);
        st_d = gbs_pkg::S_B3;
      end
      gbs_pkg::S_B3: begin
        mac_a = r0_q;
        mac_w = gbs_pkg::OneFx - s_q;
        acc_d = mac_p;
        st_d  = gbs_pkg::S_B4;
      end
      gbs_pkg::S_B4: begin
        mac_a   = r1_q;
        mac_w   = s_q;
        mac_add = 1'b1;
        acc_d   = acc_q + mac_p;
        st_d    = gbs_pkg::S_B5;
      end
      gbs_pkg::S_B5: begin
        res_d = gbs_pkg::rnd_shift(acc_q);
        st_d  = gbs_pkg::S_DONE;
      end
      gbs_pkg::S_DONE: begin
        if (out_free) begin
          ovld_d = 1'b1;
          odat_d = res_q;
          osts_d = 1'b0;
          st_d   = gbs_pkg::S_IDLE;
        end
      end
      default: st_d = gbs_pkg::S_IDLE;
    endcase
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odat_q;
  assign m_axis_tuser  = osts_q;

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (st_q == gbs_pkg::S_IDLE))
    else $error("input ready outside idle");

  a_mem_wr_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.we |-> (in_fire && (s_axis_tuser == gbs_pkg::OP_WRITE) && !in_bad))
    else $error("memory write without an accepted cell write");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser == gbs_pkg::OP_SAMPLE)) |=> !s_axis_tready)
    else $error("new transfer taken during a sample");

  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == gbs_pkg::S_DONE && out_free) |=> (m_axis_tvalid && st_q == gbs_pkg::S_IDLE))
    else $error("finished result not moved to output");

  a_mac_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_add |-> $past(st_q == gbs_pkg::S_B3))
    else $error("blend order broken");

endmodule

[verif/grid_bilinear_sampler_core_tb.sv]
`timescale 1ns / 100ps

module grid_bilinear_sampler_core_tb;

  typedef struct {
    gbs_pkg::op_e op;
    logic [5:0]   cell_x;
    logic [5:0]   cell_y;
    logic [31:0]  write_value;
    logic [31:0]  pos_x;
    logic [31:0]  pos_y;
  } grid_item_t;

  typedef struct {
    logic [31:0] value;
    logic        status;
  } grid_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  grid_bilinear_sampler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow grid and register copies
  logic [31:0]  cell_mem [gbs_pkg::Depth];
  bit           cell_written [gbs_pkg::Depth];
  logic [6:0]   cols_reg;
  logic [6:0]   rows_reg;
  logic [31:0]  inv_reg;
  logic [16:0]  cen_x_reg;
  logic [16:0]  cen_y_reg;

  grid_item_t   pending_items[$];
  grid_result_t expected_results[$];
  int           mismatches;
  bit           calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  function automatic int clamp_size(logic [6:0] r, int mx);
    if (r < 2) return 2;
    if (r > mx) return mx;
    return int'(r);
  endfunction

  // position to lower cell and fraction along one axis
  function automatic void find_cell(logic [31:0] pos, logic [16:0] cen, int size,
                                    output int lo_cell, output longint frac);
    longint p, a, hi, c, ce;
    p  = longint'($signed(pos)) * longint'({32'b0, inv_reg});
    ce = (cen > 17'd65536) ? 65536 : longint'(cen);
    a  = 0;
    if (p > 0) begin
      a = p >>> gbs_pkg::FracBits;
      a = (a > ce) ? a - ce : 0;
    end
    hi = longint'(size - 1) << gbs_pkg::FracBits;
    if (a > hi) a = hi;
    c = a >>> gbs_pkg::FracBits;
    if (c > size - 2) c = size - 2;
    lo_cell = int'(c);
    frac = a - (c << gbs_pkg::FracBits);
  endfunction

  function automatic longint round_blend(longint v);
    return (v + 32768) >>> gbs_pkg::FracBits;
  endfunction

  function automatic longint cell_val(int x, int y);
    return longint'($signed(cell_mem[y * gbs_pkg::MaxCols + x]));
  endfunction

  // expected result of one item, grid updated for writes
  function automatic grid_result_t predict_grid(grid_item_t it);
    grid_result_t res;
    int           cols, rows, x0, y0;
    longint       t, s, r0, r1;
    cols = clamp_size(cols_reg, gbs_pkg::MaxCols);
    rows = clamp_size(rows_reg, gbs_pkg::MaxRows);
    res.value  = '0;
    res.status = 1'b0;
    case (it.op)
      gbs_pkg::OP_WRITE, gbs_pkg::OP_READ: begin
        if (it.cell_x >= cols || it.cell_y >= rows) res.status = 1'b1;
        else if (it.op == gbs_pkg::OP_WRITE) begin
          cell_mem[it.cell_y * gbs_pkg::MaxCols + it.cell_x] = it.write_value;
          cell_written[it.cell_y * gbs_pkg::MaxCols + it.cell_x] = 1'b1;
        end else res.value = cell_mem[it.cell_y * gbs_pkg::MaxCols + it.cell_x];
      end
      gbs_pkg::OP_SAMPLE: begin
        find_cell(it.pos_x, cen_x_reg, cols, x0, t);
        find_cell(it.pos_y, cen_y_reg, rows, y0, s);
        r0 = round_blend(cell_val(x0, y0) * (65536 - t) + cell_val(x0 + 1, y0) * t);
        r1 = round_blend(cell_val(x0, y0 + 1) * (65536 - t) + cell_val(x0 + 1, y0 + 1) * t);
        res.value = 32'(round_blend(r0 * (65536 - s) + r1 * s));
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void issue(grid_item_t it);
    pending_items.push_back(it);
    expected_results.push_back(predict_grid(it));
  endfunction

  function automatic void issue_write(int x, int y, logic [31:0] v);
    grid_item_t it;
    it.op = gbs_pkg::OP_WRITE;
    it.cell_x = 6'(x);
    it.cell_y = 6'(y);
    it.write_value = v;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    issue(it);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // fill any cell a read or sample would touch that was never written
  function automatic void fill_cell(int x, int y);
    if (!cell_written[y * gbs_pkg::MaxCols + x]) issue_write(x, y, rand_value());
  endfunction

  function automatic void issue_read(int x, int y);
    grid_item_t it;
    if (x < clamp_size(cols_reg, gbs_pkg::MaxCols) &&
        y < clamp_size(rows_reg, gbs_pkg::MaxRows))
      fill_cell(x, y);
    it.op = gbs_pkg::OP_READ;
    it.cell_x = 6'(x);
    it.cell_y = 6'(y);
    it.write_value = $urandom;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    issue(it);
  endfunction

  function automatic void issue_sample(logic [31:0] px, logic [31:0] py);
    grid_item_t it;
    int         x0, y0;
    longint     f;
    find_cell(px, cen_x_reg, clamp_size(cols_reg, gbs_pkg::MaxCols), x0, f);
    find_cell(py, cen_y_reg, clamp_size(rows_reg, gbs_pkg::MaxRows), y0, f);
    fill_cell(x0, y0);
    fill_cell(x0 + 1, y0);
    fill_cell(x0, y0 + 1);
    fill_cell(x0 + 1, y0 + 1);
    it.op = gbs_pkg::OP_SAMPLE;
    it.cell_x = 6'($urandom);
    it.cell_y = 6'($urandom);
    it.write_value = $urandom;
    it.pos_x = px;
    it.pos_y = py;
    issue(it);
  endfunction

  // position landing mostly inside the grid, sometimes anywhere
  function automatic logic [31:0] rand_pos(int size, logic [16:0] cen);
    longint u, p;
    if ($urandom_range(0, 3) == 0 || inv_reg == 0) return $urandom;
    u = $urandom_range(0, (size + 1) << gbs_pkg::FracBits);
    p = ((u + cen) << gbs_pkg::FracBits) + $urandom_range(0, 65535);
    p = p / longint'({32'b0, inv_reg});
    if (p > 64'sh7fff_ffff) p = 64'sh7fff_ffff;
    return 32'(p);
  endfunction

  function automatic int rand_index(int size);
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, size - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic void issue_random();
    grid_item_t it;
    int         cols, rows, k;
    cols = clamp_size(cols_reg, gbs_pkg::MaxCols);
    rows = clamp_size(rows_reg, gbs_pkg::MaxRows);
    k = $urandom_range(0, 99);
    if (k < 25) issue_write(rand_index(cols), rand_index(rows), rand_value());
    else if (k < 50) issue_read(rand_index(cols), rand_index(rows));
    else if (k < 97) issue_sample(rand_pos(cols, cen_x_reg), rand_pos(rows, cen_y_reg));
    else begin
      it.op = gbs_pkg::OP_NONE;
      it.cell_x = 6'($urandom);
      it.cell_y = 6'($urandom);
      it.write_value = $urandom;
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      issue(it);
    end
  endfunction

  task automatic apb_write(gbs_pkg::reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      gbs_pkg::REG_COLS:   cols_reg  = v[6:0];
      gbs_pkg::REG_ROWS:   rows_reg  = v[6:0];
      gbs_pkg::REG_INV:    inv_reg   = v;
      gbs_pkg::REG_CENT_X: cen_x_reg = v[16:0];
      gbs_pkg::REG_CENT_Y: cen_y_reg = v[16:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] c, logic [31:0] r, logic [31:0] inv,
                           logic [31:0] cx, logic [31:0] cy);
    apb_write(gbs_pkg::REG_COLS, c);
    apb_write(gbs_pkg::REG_ROWS, r);
    apb_write(gbs_pkg::REG_INV, inv);
    apb_write(gbs_pkg::REG_CENT_X, cx);
    apb_write(gbs_pkg::REG_CENT_Y, cy);
  endtask

  // stimulus: directed items at reset settings, then random phases
  initial begin
    grid_item_t it;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    calm = 1'b0;
    cols_reg = 7'd64;
    rows_reg = 7'd64;
    inv_reg = 32'd65536;
    cen_x_reg = 17'd32768;
    cen_y_reg = 17'd32768;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue_write(0, 0, 32'h8000_0000);
    issue_write(63, 63, 32'h7fff_ffff);
    issue_write(63, 0, 32'hffff_ffff);
    issue_write(0, 63, 32'h0000_0000);
    issue_read(0, 0);
    issue_read(63, 63);
    issue_read(63, 0);
    issue_sample(32'h8000_0000, 32'h8000_0000);
    issue_sample(32'h7fff_ffff, 32'h7fff_ffff);
    issue_sample(32'h0000_0000, 32'h7fff_ffff);
    issue_sample(32'h0001_8000, 32'hffff_ffff);
    issue_sample(32'h0002_4000, 32'h0003_c000);
    it.op = gbs_pkg::OP_NONE;
    it.cell_x = 6'h3f;
    it.cell_y = 6'h3f;
    it.write_value = 32'hffff_ffff;
    it.pos_x = 32'hffff_ffff;
    it.pos_y = 32'hffff_ffff;
    issue(it);
    repeat (120) issue_random();
    drain();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: configure(2, 2, 65536, 0, 0);
        2: configure(0, 1, 1, 65536, 65536);
        3: configure(127, 127, 32'hffff_ffff, 32'h1ffff, 0);
        4: configure(5, 9, 16384, 1000, 60000);
        5: configure(64, 3, 0, 32768, 12345);
        6: configure(17, 64, 200000, 40000, 20000);
        default: configure(64, 64, 65536, 32768, 32768);
      endcase
      calm = (ph == 4);
      repeat (130) issue_random();
      drain();
    end

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // driver: one item per transfer from the pending queue
  always @(posedge clk_i) begin
    grid_item_t it;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
        it = pending_items.pop_front();
        s_axis_tdata  <= {4'b0, it.pos_y, it.pos_x, it.write_value, it.cell_y, it.cell_x};
        s_axis_tuser  <= it.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    grid_result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%h status=%b", m_axis_tdata, m_axis_tuser);
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata !== exp_res.value || m_axis_tuser !== exp_res.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch value exp %h got %h, status exp %b got %b",
                       exp_res.value, m_axis_tdata, exp_res.status, m_axis_tuser);
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

endmodule

[files.f]
rtl/core/gbs_pkg.sv
rtl/core/gbs_mem.sv
rtl/core/grid_bilinear_sampler_core.sv
verif/grid_bilinear_sampler_core_tb.sv
